/* sv/rps_pkg.sv */
package rps_pkg;

   // default sizing, handed to the top level parameters
   localparam int unsigned DEF_MAX_ELEMS  = 64;
   localparam int unsigned DEF_RAND_LIMIT = 32767;

   // fixed field widths
   localparam int RAND_W    = 15;
   localparam int NELEM_W   = 7;
   localparam int OUT_IDX_W = 6;

   // port widths, fields padded to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // generation tag kept beside each store entry
   localparam int EPOCH_W = 8;

   localparam logic [NELEM_W-1:0] NELEM_RESET = NELEM_W'(64);

endpackage

/* sv/rps_div.sv */
module rps_div #(
   parameter int DW = 15,
   parameter int SW = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] rem_init,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   input  logic [SW-1:0] steps,
   output logic          done,
   output logic [DW-1:0] quotient
);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          fits;

   // one restoring step: shift the next dividend bit into the remainder
   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = rem_init;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff - SW'(1);
         if (cnt_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* sv/random_permutation_shuffle_core.sv */
// Forward Fisher-Yates shuffle of the identity permutation, one raw random
// word per request on the req_ stream, one fixed element per response on the
// rsp_ stream, rsp_tlast marking the final element of each permutation.
// A word outside the unbiased window for the current range is dropped with
// no response. csr_wr_en/csr_wr_data set the element count (clamped to
// 1..MAX_ELEMS); write it only while the block is idle.
// Each request runs DW steps of the shared restoring divider for
// RAND_LIMIT/range, one multiply, log2(MAX_ELEMS) steps for word/group, and
// a read, read, write, write sequence on the permutation store (one write
// port, one read port). A dropped word runs the first division and the
// multiply only. req_tready is low while a request is being worked on.
// Store entries carry a generation tag; a permutation ending bumps the tag.
// After reset, and once every 2**EPOCH_W - 1 permutations, the store's
// MAX_ELEMS entries are swept to tag zero while req_tready stays low.
// A finished response sits in the rsp_ register; the next request is taken
// while it waits, and that request stalls at its end until the slot frees.
module random_permutation_shuffle_core
   import rps_pkg::*;
#(
   parameter int unsigned MAX_ELEMS  = DEF_MAX_ELEMS,
   parameter int unsigned RAND_LIMIT = DEF_RAND_LIMIT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [14:0] rand_word, [15] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] element_index,
                                              // [11:6] element_value, [15:12] zero
   output logic                  rsp_tlast,   // last_of_perm
   input  logic                  csr_wr_en,
   input  logic [NELEM_W-1:0]    csr_wr_data  // n_elems
);

   localparam int IDX_W = $clog2(MAX_ELEMS);
   localparam int CNT_W = $clog2(MAX_ELEMS + 1);
   localparam int RL_W  = $clog2(64'(RAND_LIMIT) + 64'd1);
   localparam int DW    = (RL_W > RAND_W) ? RL_W : RAND_W;
   localparam int SW    = $clog2(DW + 1);
   localparam int PW    = RL_W + CNT_W;
   localparam int LW    = (PW > RAND_W) ? PW : RAND_W;
   localparam int CMP_W = (CNT_W > NELEM_W) ? CNT_W : NELEM_W;
   localparam int OW    = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;
   localparam int MW    = EPOCH_W + IDX_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLEAR = 4'd1;
   localparam logic [3:0] ST_SWEEP = 4'd2;
   localparam logic [3:0] ST_DIV1  = 4'd3;
   localparam logic [3:0] ST_WAIT1 = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_CHK   = 4'd6;
   localparam logic [3:0] ST_WAIT2 = 4'd7;
   localparam logic [3:0] ST_RDB   = 4'd8;
   localparam logic [3:0] ST_SWAP  = 4'd9;
   localparam logic [3:0] ST_WRB   = 4'd10;
   localparam logic [3:0] ST_EMIT  = 4'd11;

   localparam logic RET_IDLE = 1'b0;
   localparam logic RET_DIV  = 1'b1;

   logic [NELEM_W-1:0] n_elems_ff;
   logic [3:0]         state_ff, state_in;
   logic               ret_ff, ret_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [IDX_W-1:0]   sweep_ff, sweep_in;
   logic [RAND_W-1:0]  word_ff, word_in;
   logic [CNT_W-1:0]   range_ff, range_in;
   logic [RL_W-1:0]    group_ff, group_in;
   logic [PW-1:0]      limit_ff, limit_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;
   logic [IDX_W-1:0]   a_ff, a_in;
   logic [IDX_W-1:0]   b_ff, b_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [OUT_IDX_W-1:0] rsp_val_ff, rsp_val_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [MW-1:0]      mem [MAX_ELEMS];
   logic [MW-1:0]      rd_data_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [MW-1:0]      mem_wdata;
   logic [IDX_W-1:0]   mem_raddr;

   logic               div_start;
   logic [DW-1:0]      div_rem;
   logic [DW-1:0]      div_dividend;
   logic [DW-1:0]      div_divisor;
   logic [SW-1:0]      div_steps;
   logic               div_done;
   logic [DW-1:0]      div_q;

   logic [CMP_W-1:0]   n_ext;
   logic [CNT_W-1:0]   n_eff;
   logic [CNT_W-1:0]   pos_cnt;
   logic [PW-1:0]      prod;
   logic [IDX_W:0]     pick_sum;
   logic               entry_hit;
   logic [IDX_W-1:0]   entry_val;
   logic [OW-1:0]      idx_ext;
   logic [OW-1:0]      val_ext;
   logic               req_fire;
   logic               last_elem;

   // effective element count, clamped to MAX_ELEMS, zero acts as one
   assign n_ext = CMP_W'(n_elems_ff);
   always_comb begin
      if (n_ext > CMP_W'(MAX_ELEMS)) begin
         n_eff = CNT_W'(MAX_ELEMS);
      end else if (n_ext == '0) begin
         n_eff = CNT_W'(1);
      end else begin
         n_eff = CNT_W'(n_ext);
      end
   end

   assign pos_cnt   = CNT_W'(pos_ff);
   assign prod      = PW'(group_ff) * PW'(range_ff);
   assign pick_sum  = (IDX_W+1)'(pos_ff) + (IDX_W+1)'(div_q[IDX_W-1:0]);
   assign entry_hit = rd_data_ff[MW-1 -: EPOCH_W] == epoch_ff;
   assign entry_val = rd_data_ff[IDX_W-1:0];
   assign idx_ext   = OW'(pos_ff);
   assign val_ext   = OW'(b_ff);
   assign last_elem = pos_cnt == (n_eff - CNT_W'(1));
   assign req_tready = state_ff == ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      pos_in       = pos_ff;
      epoch_in     = epoch_ff;
      sweep_in     = sweep_ff;
      word_in      = word_ff;
      range_in     = range_ff;
      group_in     = group_ff;
      limit_in     = limit_ff;
      pick_in      = pick_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = {epoch_ff, b_in};
      mem_raddr    = pos_ff;
      div_start    = 1'b0;
      div_rem      = '0;
      div_dividend = DW'(RAND_LIMIT);
      div_divisor  = DW'(range_ff);
      div_steps    = SW'(DW);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               word_in = req_tdata[RAND_W-1:0];
               // count lowered since the last request: start a fresh permutation
               if (pos_cnt >= n_eff) begin
                  pos_in   = '0;
                  ret_in   = RET_DIV;
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_DIV1;
               end
            end
         end
         ST_CLEAR: begin
            if (epoch_ff == '1) begin
               epoch_in = EPOCH_W'(1);
               sweep_in = '0;
               state_in = ST_SWEEP;
            end else begin
               epoch_in = epoch_ff + EPOCH_W'(1);
               state_in = (ret_ff == RET_DIV) ? ST_DIV1 : ST_IDLE;
            end
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            if (sweep_ff == IDX_W'(MAX_ELEMS - 1)) begin
               state_in = (ret_ff == RET_DIV) ? ST_DIV1 : ST_IDLE;
            end else begin
               sweep_in = sweep_ff + IDX_W'(1);
            end
         end
         ST_DIV1: begin
            range_in    = n_eff - pos_cnt;
            div_start   = 1'b1;
            div_divisor = DW'(n_eff - pos_cnt);
            state_in    = ST_WAIT1;
         end
         ST_WAIT1: begin
            if (div_done) begin
               group_in = (div_q == '0) ? RL_W'(1) : RL_W'(div_q);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            limit_in = prod;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (LW'(word_ff) >= LW'(limit_ff)) begin
               state_in = ST_IDLE;
            end else begin
               // quotient is below the range, so only IDX_W steps are needed
               div_start    = 1'b1;
               div_rem      = DW'(word_ff >> IDX_W);
               div_dividend = DW'(word_ff[IDX_W-1:0]) << (DW - IDX_W);
               div_divisor  = DW'(group_ff);
               div_steps    = SW'(IDX_W);
               state_in     = ST_WAIT2;
            end
         end
         ST_WAIT2: begin
            if (div_done) begin
               if (pick_sum >= (IDX_W+1)'(n_eff)) begin
                  pick_in = IDX_W'(n_eff - CNT_W'(1));
               end else begin
                  pick_in = IDX_W'(pick_sum);
               end
               state_in = ST_RDB;
            end
         end
         ST_RDB: begin
            a_in      = entry_hit ? entry_val : pos_ff;
            mem_raddr = pick_ff;
            state_in  = ST_SWAP;
         end
         ST_SWAP: begin
            b_in      = entry_hit ? entry_val : pick_ff;
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = {epoch_ff, b_in};
            state_in  = ST_WRB;
         end
         ST_WRB: begin
            mem_we    = 1'b1;
            mem_waddr = pick_ff;
            mem_wdata = {epoch_ff, a_ff};
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_ext[OUT_IDX_W-1:0];
               rsp_val_in   = val_ext[OUT_IDX_W-1:0];
               rsp_last_in  = last_elem;
               if (last_elem) begin
                  pos_in   = '0;
                  ret_in   = RET_IDLE;
                  state_in = ST_CLEAR;
               end else begin
                  pos_in   = pos_ff + IDX_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_elems_ff   <= NELEM_RESET;
         state_ff     <= ST_SWEEP;
         ret_ff       <= RET_IDLE;
         pos_ff       <= '0;
         epoch_ff     <= EPOCH_W'(1);
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            n_elems_ff <= csr_wr_data;
         end
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         pos_ff       <= pos_in;
         epoch_ff     <= epoch_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff     <= word_in;
      range_ff    <= range_in;
      group_ff    <= group_in;
      limit_ff    <= limit_in;
      pick_ff     <= pick_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   // permutation store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   rps_div #(
      .DW (DW),
      .SW (SW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_val_ff, rsp_idx_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* sv/rps_checker.sv */
module rps_checker
   import rps_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // one request at a time: busy right after a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in flight");

   // a response never appears in the cycle right after a request
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("response too soon after request");

   // leaving reset the store is being swept and no response is pending
   a_reset_sweep: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready && !rsp_tvalid)
      else $error("block ready or responding right after reset");

endmodule

bind random_permutation_shuffle_core rps_checker u_rps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
